### rtl/css_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// css_pkg: shared types and constants for the cosine similarity stream
// Widths follow from the longest vector that is accumulated exactly.
// ---------------------------------------------------------------------------
package css_pkg;

   // longest vector that is accumulated; later pairs are dropped
   localparam int MAX_LEN  = 1024;
   localparam int LEN_LOG  = $clog2(MAX_LEN);
   localparam int CNT_W    = $clog2(MAX_LEN + 1);

   // element and product widths (Q3.12 elements)
   localparam int ELEM_W   = 16;
   localparam int PROD_W   = 2 * ELEM_W;      // signed a*b
   localparam int SQR_W    = 2 * ELEM_W - 1;  // a*a <= 2^30

   // accumulators: sum of squares and signed dot product
   localparam int SQ_W     = SQR_W + LEN_LOG;
   localparam int DOT_W    = SQ_W + 1;

   // back end arithmetic
   localparam int P_W      = 2 * SQ_W;        // sa*sb and dot^2
   localparam int SUM_W    = P_W + 34;        // o^2*P, dot^2*2^32, with headroom
   localparam int OP_W     = P_W + 16;        // o*P
   localparam int U_W      = 15;              // magnitude minus one
   localparam int BIT_W    = $clog2(U_W);
   localparam int MCNT_W   = $clog2(SQ_W);
   localparam int COS_W    = 16;
   localparam int SHIFT_W  = 5;

   // request queue between front and back
   localparam int QDEPTH   = 2;
   localparam int QPTR_W   = $clog2(QDEPTH);
   localparam int QCNT_W   = $clog2(QDEPTH + 1);

   // one finished vector pair, handed from front to back
   typedef struct packed {
      logic signed [DOT_W-1:0] dot;
      logic [SQ_W-1:0]         sum_a;
      logic [SQ_W-1:0]         sum_b;
      logic                    too_long;
   } job_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL,
      BK_CHECK,
      BK_ADD,
      BK_CMP,
      BK_OUT
   } back_state_type;

endpackage

### rtl/css_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// css_front: request intake and exact accumulation
// Registers the element products, then adds them into the dot product and
// the two sums of squares. A request marked last hands the totals to the
// queue and clears the accumulators.
// ---------------------------------------------------------------------------
module css_front import css_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [2*ELEM_W-1:0]     req_tdata,
   input  logic                    req_tlast,
   input  logic [QCNT_W-1:0]       q_count,
   output logic                    push_valid,
   output job_type                 push_job
);

   logic                    accept;
   logic signed [ELEM_W-1:0] elem_a;
   logic signed [ELEM_W-1:0] elem_b;

   logic                    s1_valid_ff, s1_valid_in;
   logic                    s1_last_ff,  s1_last_in;
   logic signed [PROD_W-1:0] prod_ab_ff, prod_ab_in;
   logic [SQR_W-1:0]        prod_aa_ff, prod_aa_in;
   logic [SQR_W-1:0]        prod_bb_ff, prod_bb_in;

   logic signed [DOT_W-1:0] dot_ff, dot_in;
   logic [SQ_W-1:0]         sum_a_ff, sum_a_in;
   logic [SQ_W-1:0]         sum_b_ff, sum_b_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    ovf_ff, ovf_in;

   logic signed [DOT_W-1:0] dot_acc;
   logic [SQ_W-1:0]         sum_a_acc;
   logic [SQ_W-1:0]         sum_b_acc;
   logic [CNT_W-1:0]        count_acc;
   logic                    ovf_acc;
   logic                    pending;

   assign elem_a = req_tdata[ELEM_W-1:0];
   assign elem_b = req_tdata[2*ELEM_W-1:ELEM_W];

   // leave room for a last request already in the product stage
   assign pending    = s1_valid_ff & s1_last_ff;
   assign req_tready = ({1'b0, q_count} + {{QCNT_W{1'b0}}, pending})
                       < (QCNT_W+1)'(QDEPTH);
   assign accept     = req_tvalid & req_tready;

   // product stage
   always_comb begin
      s1_valid_in = accept;
      s1_last_in  = req_tlast;
      prod_ab_in  = PROD_W'(elem_a * elem_b);
      prod_aa_in  = SQR_W'(unsigned'(PROD_W'(elem_a * elem_a)));
      prod_bb_in  = SQR_W'(unsigned'(PROD_W'(elem_b * elem_b)));
   end

   // accumulate stage; pairs past the length limit only raise the flag
   always_comb begin
      dot_acc   = dot_ff;
      sum_a_acc = sum_a_ff;
      sum_b_acc = sum_b_ff;
      count_acc = count_ff;
      ovf_acc   = ovf_ff;
      if (s1_valid_ff) begin
         if (count_ff < CNT_W'(MAX_LEN)) begin
            dot_acc   = dot_ff + DOT_W'(prod_ab_ff);
            sum_a_acc = sum_a_ff + SQ_W'(prod_aa_ff);
            sum_b_acc = sum_b_ff + SQ_W'(prod_bb_ff);
            count_acc = count_ff + CNT_W'(1);
         end else begin
            ovf_acc = 1'b1;
         end
      end

      push_valid        = s1_valid_ff & s1_last_ff;
      push_job.dot      = dot_acc;
      push_job.sum_a    = sum_a_acc;
      push_job.sum_b    = sum_b_acc;
      push_job.too_long = ovf_acc;

      if (push_valid) begin
         dot_in   = '0;
         sum_a_in = '0;
         sum_b_in = '0;
         count_in = '0;
         ovf_in   = 1'b0;
      end else begin
         dot_in   = dot_acc;
         sum_a_in = sum_a_acc;
         sum_b_in = sum_b_acc;
         count_in = count_acc;
         ovf_in   = ovf_acc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         dot_ff      <= '0;
         sum_a_ff    <= '0;
         sum_b_ff    <= '0;
         count_ff    <= '0;
         ovf_ff      <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         dot_ff      <= dot_in;
         sum_a_ff    <= sum_a_in;
         sum_b_ff    <= sum_b_in;
         count_ff    <= count_in;
         ovf_ff      <= ovf_in;
      end
   end

   // product payload
   always_ff @(posedge clock) begin
      s1_last_ff <= s1_last_in;
      prod_ab_ff <= prod_ab_in;
      prod_aa_ff <= prod_aa_in;
      prod_bb_ff <= prod_bb_in;
   end

endmodule

### rtl/css_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// css_queue: short queue of finished vector totals
// Lets the front keep accepting requests while the back is still dividing.
// ---------------------------------------------------------------------------
module css_queue import css_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  job_type           push_job,
   input  logic              pop,
   output logic              pop_valid,
   output job_type           pop_job,
   output logic [QCNT_W-1:0] count
);

   job_type             entry_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff,  count_in;
   logic                do_pop;

   assign pop_valid = count_ff != '0;
   assign pop_job   = entry_ff[rd_ptr_ff];
   assign count     = count_ff;
   assign do_pop    = pop & pop_valid;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push_valid && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (!push_valid && do_pop) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

### rtl/css_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// css_back: normalizing divide and result register
// Forms sa*sb and dot^2 with a shift-add multiplier, then finds the cosine
// magnitude bit by bit in add and compare states, comparing o^2*sa*sb with
// dot^2*2^32, o = 2*magnitude - 1, kept up by shifts and adds.
// ---------------------------------------------------------------------------
module css_back import css_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_valid,
   input  job_type            job,
   output logic               job_pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [COS_W-1:0]   rsp_tdata,
   output logic [1:0]         rsp_tuser
);

   back_state_type state_ff, state_in;

   logic              neg_ff, neg_in;
   logic              zn_ff, zn_in;
   logic              tl_ff, tl_in;
   logic [P_W-1:0]    mcand_p_ff, mcand_p_in;
   logic [SQ_W-1:0]   mplier_p_ff, mplier_p_in;
   logic [P_W-1:0]    acc_p_ff, acc_p_in;
   logic [P_W-1:0]    mcand_r_ff, mcand_r_in;
   logic [SQ_W-1:0]   mplier_r_ff, mplier_r_in;
   logic [P_W-1:0]    acc_r_ff, acc_r_in;
   logic [MCNT_W-1:0] cnt_ff, cnt_in;
   logic [SUM_W-1:0]  sq_ff, sq_in;
   logic [OP_W-1:0]   op_ff, op_in;
   logic [SUM_W-1:0]  cand_ff, cand_in;
   logic [U_W-1:0]    u_ff, u_in;
   logic [BIT_W-1:0]  bit_ff, bit_in;
   logic [COS_W-1:0]  cos_ff, cos_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [COS_W-1:0]  rsp_cos_ff, rsp_cos_in;
   logic [1:0]        rsp_flags_ff, rsp_flags_in;

   logic [DOT_W-1:0]  dot_abs;
   logic [SUM_W-1:0]  p_ext;
   logic [SUM_W-1:0]  r_ext;
   logic [SHIFT_W-1:0] sh_op;
   logic [SHIFT_W-1:0] sh_p;
   logic [SHIFT_W-1:0] sh_inc;
   logic [U_W-1:0]    u_set;
   logic [COS_W-1:0]  mag;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_cos_ff;
   assign rsp_tuser  = rsp_flags_ff;

   assign dot_abs = job.dot[DOT_W-1] ? DOT_W'(-job.dot) : DOT_W'(job.dot);
   assign p_ext   = SUM_W'(acc_p_ff);
   assign r_ext   = SUM_W'(acc_r_ff) << 32;
   assign sh_op   = SHIFT_W'(bit_ff) + SHIFT_W'(2);
   assign sh_p    = SHIFT_W'({bit_ff, 1'b0}) + SHIFT_W'(2);
   assign sh_inc  = SHIFT_W'(bit_ff) + SHIFT_W'(1);
   assign u_set   = u_ff | (U_W'(1) << bit_ff);
   assign mag     = COS_W'(u_set) + COS_W'(1);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      neg_in       = neg_ff;
      zn_in        = zn_ff;
      tl_in        = tl_ff;
      mcand_p_in   = mcand_p_ff;
      mplier_p_in  = mplier_p_ff;
      acc_p_in     = acc_p_ff;
      mcand_r_in   = mcand_r_ff;
      mplier_r_in  = mplier_r_ff;
      acc_r_in     = acc_r_ff;
      cnt_in       = cnt_ff;
      sq_in        = sq_ff;
      op_in        = op_ff;
      cand_in      = cand_ff;
      u_in         = u_ff;
      bit_in       = bit_ff;
      cos_in       = cos_ff;
      job_pop      = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_cos_in   = rsp_cos_ff;
      rsp_flags_in = rsp_flags_ff;

      case (state_ff)
         BK_IDLE: begin
            if (job_valid) begin
               job_pop     = 1'b1;
               neg_in      = job.dot[DOT_W-1];
               zn_in       = (job.sum_a == '0) || (job.sum_b == '0);
               tl_in       = job.too_long;
               mcand_p_in  = P_W'(job.sum_a);
               mplier_p_in = job.sum_b;
               mcand_r_in  = P_W'(dot_abs[SQ_W-1:0]);
               mplier_r_in = dot_abs[SQ_W-1:0];
               acc_p_in    = '0;
               acc_r_in    = '0;
               cnt_in      = '0;
               cos_in      = '0;
               if ((job.sum_a == '0) || (job.sum_b == '0)) begin
                  state_in = BK_OUT;
               end else begin
                  state_in = BK_MUL;
               end
            end
         end
         // one multiplier bit per cycle for both products
         BK_MUL: begin
            if (mplier_p_ff[0]) begin
               acc_p_in = acc_p_ff + mcand_p_ff;
            end
            if (mplier_r_ff[0]) begin
               acc_r_in = acc_r_ff + mcand_r_ff;
            end
            mcand_p_in  = mcand_p_ff << 1;
            mcand_r_in  = mcand_r_ff << 1;
            mplier_p_in = mplier_p_ff >> 1;
            mplier_r_in = mplier_r_ff >> 1;
            cnt_in      = cnt_ff + MCNT_W'(1);
            if (cnt_ff == MCNT_W'(SQ_W - 1)) begin
               state_in = BK_CHECK;
            end
         end
         // magnitude one must pass, otherwise the result rounds to zero
         BK_CHECK: begin
            if (p_ext <= r_ext) begin
               sq_in    = p_ext;
               op_in    = OP_W'(acc_p_ff);
               u_in     = '0;
               bit_in   = BIT_W'(U_W - 1);
               state_in = BK_ADD;
            end else begin
               cos_in   = '0;
               state_in = BK_OUT;
            end
         end
         // trial square for the current bit
         BK_ADD: begin
            cand_in  = sq_ff + (SUM_W'(op_ff) << sh_op) + (p_ext << sh_p);
            state_in = BK_CMP;
         end
         BK_CMP: begin
            if (cand_ff <= r_ext) begin
               sq_in = cand_ff;
               op_in = op_ff + (OP_W'(acc_p_ff) << sh_inc);
               u_in  = u_set;
            end
            if (bit_ff == '0) begin
               if (neg_ff) begin
                  cos_in = COS_W'(-((cand_ff <= r_ext) ? mag : COS_W'(u_ff) + COS_W'(1)));
               end else if (cand_ff <= r_ext) begin
                  cos_in = mag[COS_W-1] ? {1'b0, {(COS_W-1){1'b1}}} : mag;
               end else begin
                  cos_in = COS_W'(u_ff) + COS_W'(1);
               end
               state_in = BK_OUT;
            end else begin
               bit_in   = bit_ff - BIT_W'(1);
               state_in = BK_ADD;
            end
         end
         // load the result register once it is free
         BK_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_cos_in   = cos_ff;
               rsp_flags_in = {tl_ff, zn_ff};
               state_in     = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath payload
   always_ff @(posedge clock) begin
      neg_ff       <= neg_in;
      zn_ff        <= zn_in;
      tl_ff        <= tl_in;
      mcand_p_ff   <= mcand_p_in;
      mplier_p_ff  <= mplier_p_in;
      acc_p_ff     <= acc_p_in;
      mcand_r_ff   <= mcand_r_in;
      mplier_r_ff  <= mplier_r_in;
      acc_r_ff     <= acc_r_in;
      cnt_ff       <= cnt_in;
      sq_ff        <= sq_in;
      op_ff        <= op_in;
      cand_ff      <= cand_in;
      u_ff         <= u_in;
      bit_ff       <= bit_in;
      cos_ff       <= cos_in;
      rsp_cos_ff   <= rsp_cos_in;
      rsp_flags_ff <= rsp_flags_in;
   end

endmodule

### rtl/cosine_similarity_stream.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cosine_similarity_stream: streaming cosine similarity of two vectors
// Each request carries one element pair (Q3.12) on req_tdata, req_tlast
// marking the final pair. The request with req_tlast produces one response:
// the cosine in Q1.15 on rsp_tdata, zero-norm and too-long flags on rsp_tuser.
// Requests are taken one per cycle while req_tready is high; each pair
// passes a product register and is then added into the front accumulators,
// which hold the exact dot product and both sums of squares. A finished
// vector pair queues (two deep) for the back end, which takes the job, runs
// a shift-add multiply and a range check, then the 15-bit search with an
// add and a compare state per bit, and loads the response register; a
// zero norm goes straight to loading it. The next vector accumulates
// meanwhile. Pairs past MAX_LEN are dropped and set the too-long flag; a
// zero norm gives cosine 0 with the zero-norm flag.
// Reset clears the accumulators, the queue and the response register.
// A stalled response holds in the output register; the queue absorbs up to
// two more finished vectors, after which req_tready drops.
// ---------------------------------------------------------------------------
module cosine_similarity_stream import css_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [2*ELEM_W-1:0] req_tdata,   // elem_a [15:0], elem_b [31:16]
   input  logic                req_tlast,   // last
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [COS_W-1:0]    rsp_tdata,   // cosine [15:0]
   output logic [1:0]          rsp_tuser    // zero_norm [0], too_long [1]
);

   logic              push_valid;
   job_type           push_job;
   logic              pop;
   logic              pop_valid;
   job_type           pop_job;
   logic [QCNT_W-1:0] q_count;

   css_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_count    (q_count),
      .push_valid (push_valid),
      .push_job   (push_job)
   );

   css_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_job    (pop_job),
      .count      (q_count)
   );

   css_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (pop_valid),
      .job        (pop_job),
      .job_pop    (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

### rtl/css_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// css_checker: port-level checks for the cosine similarity stream
// Watches the response channel for stall stability, flag consistency and reset.
// ---------------------------------------------------------------------------
module css_checker import css_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [COS_W-1:0] rsp_tdata,
   input  logic [1:0]       rsp_tuser
);

   // a stalled response keeps its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // a zero norm always reports cosine zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("zero norm with nonzero cosine");

   // no response comes straight out of reset
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind cosine_similarity_stream css_checker u_css_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

### verif/cosine_similarity_stream_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cosine_similarity_stream_test: self-checking bench for the cosine stream
// Feeds element pairs through the request channel with random gaps. A local
// model accumulates dot product and sums of squares exactly and computes the
// expected Q1.15 cosine by an integer search on wide vectors. Responses are
// compared field by field in order while the response side stalls at random.
// ---------------------------------------------------------------------------
module cosine_similarity_stream_test;
   import css_pkg::*;

   localparam int IDLE_LIMIT   = 4000;   // cycles without any handshake
   localparam int DRAIN_CYCLES = 200;
   localparam int RANDOM_PAIRS = 500;
   localparam int ZERO_NORM_BIT = 0;
   localparam int TOO_LONG_BIT  = 1;

   typedef struct {
      logic signed [ELEM_W-1:0] a;
      logic signed [ELEM_W-1:0] b;
      logic                     last;
   } pair_type;

   typedef struct {
      logic signed [COS_W-1:0] cosine;
      logic                    zero_norm;
      logic                    too_long;
   } cosine_result_type;

   typedef enum int {
      VK_RANDOM,
      VK_SMALL,
      VK_SAME,
      VK_OPPOSITE,
      VK_ONE_ZERO
   } vector_kind_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [2*ELEM_W-1:0] req_tdata = '0;   // elem_a [15:0], elem_b [31:16]
   logic req_tlast = 1'b0;                // last
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [COS_W-1:0] rsp_tdata;           // cosine [15:0]
   logic [1:0] rsp_tuser;                 // zero_norm [0], too_long [1]

   // pending requests and expected responses
   pair_type          pending_pairs[$];
   cosine_result_type cosine_expected_q[$];

   // model accumulators
   longint          dot_acc;
   longint unsigned energy_a;
   longint unsigned energy_b;
   int unsigned     pairs_taken;
   bit              excess_seen;

   // bookkeeping
   int errors = 0;
   int pairs_sent = 0;
   int vectors_sent = 0;
   int responses_checked = 0;
   int zero_norm_seen = 0;
   int too_long_seen = 0;
   int idle_cycles = 0;
   int send_gap = 0;
   int recv_hold = 0;
   bit send_burst = 1'b0;
   bit recv_burst = 1'b0;
   pair_type next_pair;

   cosine_similarity_stream dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // cosine = dot / sqrt(sa*sb) in Q1.15, round half away from zero:
   // largest k with (2k-1)^2 * sa * sb <= dot^2 * 2^32
   function automatic cosine_result_type cosine_q15(input longint dot,
                                                    input longint unsigned sa,
                                                    input longint unsigned sb);
      cosine_result_type res;
      logic [127:0]      target;
      logic [127:0]      energy;
      logic [127:0]      odd;
      logic [63:0]       mag;
      int unsigned       lo;
      int unsigned       hi;
      int unsigned       mid;
      res.cosine = '0;
      res.zero_norm = 1'b0;
      res.too_long = 1'b0;
      if (sa == 0 || sb == 0) begin
         res.zero_norm = 1'b1;
         return res;
      end
      mag = (dot < 0) ? 64'(-dot) : 64'(dot);
      target = (128'(mag) * 128'(mag)) << 32;
      energy = 128'(sa) * 128'(sb);
      lo = 0;
      hi = 32768;
      while (lo < hi) begin
         mid = lo + (hi - lo + 1) / 2;
         odd = 128'(2 * mid - 1);
         if (odd * odd * energy <= target) lo = mid;
         else hi = mid - 1;
      end
      if (dot < 0) res.cosine = COS_W'(-int'(lo));
      else res.cosine = (lo > 32767) ? COS_W'(32767) : COS_W'(lo);
      return res;
   endfunction

   // fold one accepted request into the accumulators
   task automatic fold_pair(input logic signed [ELEM_W-1:0] a,
                            input logic signed [ELEM_W-1:0] b,
                            input logic last);
      cosine_result_type res;
      if (pairs_taken < MAX_LEN) begin
         dot_acc  += longint'(a) * longint'(b);
         energy_a += longint'(a) * longint'(a);
         energy_b += longint'(b) * longint'(b);
         pairs_taken++;
      end else begin
         excess_seen = 1'b1;
      end
      if (last) begin
         res = cosine_q15(dot_acc, energy_a, energy_b);
         res.too_long = excess_seen;
         cosine_expected_q.insert(cosine_expected_q.size(), res);
         dot_acc = 0;
         energy_a = 0;
         energy_b = 0;
         pairs_taken = 0;
         excess_seen = 1'b0;
      end
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
      errors++;
   endtask

   task automatic add_pair(input int a, input int b, input bit last);
      pair_type p;
      p.a = ELEM_W'(a);
      p.b = ELEM_W'(b);
      p.last = last;
      pending_pairs.insert(pending_pairs.size(), p);
      if (last) vectors_sent++;
   endtask

   function automatic int rand_elem();
      return int'($urandom_range(0, 65535)) - 32768;
   endfunction

   // one vector pair of the given kind and length
   task automatic add_vector(input vector_kind_type kind, input int len);
      int a;
      int b;
      int scale;
      scale = $urandom_range(1, 4);
      for (int i = 0; i < len; i++) begin
         case (kind)
            VK_RANDOM: begin
               a = rand_elem();
               b = rand_elem();
            end
            VK_SMALL: begin
               a = int'($urandom_range(0, 8)) - 4;
               b = int'($urandom_range(0, 8)) - 4;
            end
            VK_SAME: begin
               a = rand_elem() / scale;
               b = a * scale;
            end
            VK_OPPOSITE: begin
               a = int'($urandom_range(0, 65534)) - 32767;
               b = -a;
            end
            default: begin
               a = 0;
               b = rand_elem();
            end
         endcase
         if (kind == VK_ONE_ZERO && len[0]) add_pair(b, a, i == len - 1);
         else add_pair(a, b, i == len - 1);
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            fold_pair(signed'(req_tdata[ELEM_W-1:0]),
                      signed'(req_tdata[2*ELEM_W-1:ELEM_W]), req_tlast);
            pairs_sent++;
         end
         if (send_gap > 0 || pending_pairs.size() == 0) begin
            req_tvalid <= 1'b0;
            if (send_gap > 0) send_gap--;
         end else begin
            next_pair = pending_pairs.pop_front();
            req_tdata <= {next_pair.b, next_pair.a};
            req_tlast <= next_pair.last;
            req_tvalid <= 1'b1;
            if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
            send_gap = send_burst ? 0 : $urandom_range(0, 17);
         end
      end
   end

   // response monitor, random stalls and watchdog
   always @(posedge clock) begin
      cosine_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            responses_checked++;
            if (rsp_tuser[ZERO_NORM_BIT]) zero_norm_seen++;
            if (rsp_tuser[TOO_LONG_BIT]) too_long_seen++;
            if (cosine_expected_q.size() == 0) begin
               report_mismatch("unexpected response cosine", signed'(rsp_tdata), 0);
            end else begin
               want = cosine_expected_q.pop_front();
               if (rsp_tdata !== want.cosine)
                  report_mismatch("cosine", signed'(rsp_tdata), want.cosine);
               if (rsp_tuser[ZERO_NORM_BIT] !== want.zero_norm)
                  report_mismatch("zero_norm", rsp_tuser[ZERO_NORM_BIT], want.zero_norm);
               if (rsp_tuser[TOO_LONG_BIT] !== want.too_long)
                  report_mismatch("too_long", rsp_tuser[TOO_LONG_BIT], want.too_long);
            end
            if ($urandom_range(0, 7) == 0) recv_burst = !recv_burst;
            recv_hold = recv_burst ? 0 : $urandom_range(0, 17);
         end else if (recv_hold > 0 && (rsp_tvalid || $urandom_range(0, 3) == 0)) begin
            recv_hold--;
         end
         rsp_tready <= (recv_hold == 0);

         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // stimulus and end of run
   initial begin
      int kind_pick;
      int base_pairs;
      dot_acc = 0;
      energy_a = 0;
      energy_b = 0;
      pairs_taken = 0;
      excess_seen = 1'b0;

      // directed: zero norms on either side and both
      add_pair(0, 5, 1'b1);
      add_pair(5, 0, 1'b1);
      add_pair(0, 0, 1'b1);
      add_pair(0, 7, 1'b0);
      add_pair(0, -3, 1'b1);
      // plus one saturates, minus one is exact
      add_pair(-32768, -32768, 1'b1);
      add_pair(32767, 32767, 1'b1);
      add_pair(-32768, 32767, 1'b1);
      add_pair(1, -1, 1'b1);
      // orthogonal, 45 degrees, mixed extremes
      add_pair(32767, 0, 1'b0);
      add_pair(0, 32767, 1'b1);
      add_pair(1, 0, 1'b0);
      add_pair(1, 1, 1'b1);
      add_pair(-32768, 32767, 1'b0);
      add_pair(32767, -32768, 1'b0);
      add_pair(-1, 1, 1'b0);
      add_pair(12345, -23456, 1'b1);

      // longest vector with the largest positive accumulators, then one more
      // pair marked last: it is dropped but still answers
      for (int i = 0; i < MAX_LEN; i++) add_pair(-32768, -32768, 1'b0);
      add_pair(rand_elem(), rand_elem(), 1'b1);

      // random vectors, mostly short
      base_pairs = pending_pairs.size();
      while (pending_pairs.size() < base_pairs + RANDOM_PAIRS) begin
         kind_pick = $urandom_range(0, 9);
         add_vector(kind_pick < 4 ? VK_RANDOM :
                    kind_pick < 6 ? VK_SMALL :
                    kind_pick < 7 ? VK_SAME :
                    kind_pick < 8 ? VK_OPPOSITE : VK_ONE_ZERO,
                    ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64)
                                                : $urandom_range(1, 16));
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (pending_pairs.size() != 0 || req_tvalid || cosine_expected_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d vector pairs in %0d requests; checked %0d responses",
               vectors_sent, pairs_sent, responses_checked);
      $display("Flags seen: %0d zero-norm, %0d too-long", zero_norm_seen, too_long_seen);
      if (errors == 0 && cosine_expected_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

### files.f
rtl/css_pkg.sv
rtl/css_front.sv
rtl/css_queue.sv
rtl/css_back.sv
rtl/cosine_similarity_stream.sv
rtl/css_checker.sv
verif/cosine_similarity_stream_test.sv
